@@ src/dmat_pkg.sv @@
// ----------------------------------------------------------------------------
// dmat_pkg: shared types, character codes and helpers
// Parser state encoding, byte constants and the lookup functions used by the
// dollar markup translator.
// ----------------------------------------------------------------------------
`default_nettype none

package dmat_pkg;

  // number of byte slots in one expansion job (longest is the colour code)
  localparam int unsigned JOB_SLOTS = 19;

  // character codes
  localparam logic [7:0] CH_ESC    = 8'h1b;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LBRK   = 8'h5b;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_M      = 8'h6d;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_4      = 8'h34;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF_HEX = 8'h66;
  localparam logic [7:0] CH_G      = 8'h67;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_O      = 8'h6f;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_Z      = 8'h7a;

  // hex letter offset
  localparam logic [3:0] HEX_TEN = 4'ha;

  // parser state, one-hot
  typedef enum logic [3:0] {
    P_TEXT  = 4'b0001,
    P_CODE  = 4'b0010,
    P_GREEN = 4'b0100,
    P_BLUE  = 4'b1000
  } parse_mode_t;

  typedef logic [7:0] byte_t;

  // hex digit decode: {valid, value}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      r = {1'b1, 4'(c - CH_0)};
    end else if (c >= CH_UA && c <= CH_UF) begin
      r = {1'b1, 4'(c - CH_UA) + HEX_TEN};
    end else if (c >= CH_LA && c <= CH_LF_HEX) begin
      r = {1'b1, 4'(c - CH_LA) + HEX_TEN};
    end
    return r;
  endfunction

  // digit times 15 as three ascii characters {hundreds, tens, ones}
  function automatic logic [23:0] dec15(input logic [3:0] d);
    logic [23:0] r;
    case (d)
      4'd0:    r = "000";
      4'd1:    r = "015";
      4'd2:    r = "030";
      4'd3:    r = "045";
      4'd4:    r = "060";
      4'd5:    r = "075";
      4'd6:    r = "090";
      4'd7:    r = "105";
      4'd8:    r = "120";
      4'd9:    r = "135";
      4'd10:   r = "150";
      4'd11:   r = "165";
      4'd12:   r = "180";
      4'd13:   r = "195";
      4'd14:   r = "210";
      4'd15:   r = "225";
      default: r = "000";
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/dollar_markup_to_ansi_translator.sv @@
// ----------------------------------------------------------------------------
// dollar_markup_to_ansi_translator: dollar markup to terminal escape bytes
// Parses dollar style codes in a text byte stream and expands them into
// terminal escape sequences, at most one output byte per cycle.
// ----------------------------------------------------------------------------
// in_*  : one text byte per item in in_tdata
// out_* : one translated byte per item; out_tlast marks the final byte caused
//         by one input byte; silent input bytes (dollar, colour digits,
//         dropped codes) cause no output item
// cfg_* : writes the reset_on_newline bit; always ready
// Throughput: an accepted item fills the job buffer; its bytes then pass one
//   by one through the output register. Plain text runs at one byte per cycle
//   while out_tready is high; a colour code (up to 19 bytes) holds off the
//   input until its last byte moves to the output register
// Reset (rst_n low, synchronous): parser back to plain text, colour digits and
//   the config bit clear, pending bytes discarded
// Stall: while out_tready is low the output register holds its byte and the
//   job stops advancing; in_tready is high only when the job is empty or its
//   last byte moves to the output in this cycle
// ----------------------------------------------------------------------------
`default_nettype none

module dollar_markup_to_ansi_translator
  import dmat_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] text_byte
  // output stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] out_byte
  output logic            out_tlast,  // last_of_run
  // config write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data    // reset_on_newline
);

  // registers
  parse_mode_t           mode_r, mode_nxt;
  logic [3:0]            red_r, red_nxt;
  logic [3:0]            green_r, green_nxt;
  logic                  rst_nl_r;
  byte_t                 job_buf_r [JOB_SLOTS];
  byte_t                 new_buf   [JOB_SLOTS];
  logic [JOB_SLOTS-1:0]  job_mask_r, job_mask_nxt, new_mask;
  logic                  out_valid_r;
  logic [7:0]            out_data_r;
  logic                  out_last_r;

  // handshake terms
  logic                  in_fire;
  logic                  out_load;
  logic                  emit;
  logic                  job_last;
  logic [JOB_SLOTS-1:0]  low_bit;
  byte_t                 emit_byte;

  logic [4:0]            hv;
  logic [3:0]            dz;
  logic [23:0]           dr, dg, db;

  assign cfg_ready = 1'b1;

  // slot selection: lowest pending slot goes out next
  assign low_bit  = job_mask_r & (~job_mask_r + {{(JOB_SLOTS-1){1'b0}}, 1'b1});
  assign job_last = (job_mask_r != '0) && ((job_mask_r & ~low_bit) == '0);
  assign out_load = !out_valid_r || out_tready;
  assign emit     = (job_mask_r != '0) && out_load;
  assign in_tready = (job_mask_r == '0) || (job_last && out_load);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    emit_byte = '0;
    for (int k = 0; k < JOB_SLOTS; k++) begin
      if (low_bit[k]) begin
        emit_byte = emit_byte | job_buf_r[k];
      end
    end
  end

  // decode of the incoming byte into a job
  assign hv = hex_val(in_tdata);
  assign dz = hv[4] ? hv[3:0] : 4'd0;
  assign dr = dec15(red_r);
  assign dg = dec15(green_r);
  assign db = dec15(dz);

  always_comb begin
    mode_nxt  = mode_r;
    red_nxt   = red_r;
    green_nxt = green_r;
    new_mask  = '0;
    for (int k = 0; k < JOB_SLOTS; k++) begin
      new_buf[k] = '0;
    end
    case (mode_r)
      P_TEXT: begin
        if (in_tdata == CH_DOLLAR) begin
          mode_nxt = P_CODE;
        end else if (in_tdata == CH_LF && rst_nl_r) begin
          new_buf[0] = CH_ESC;
          new_buf[1] = CH_LBRK;
          new_buf[2] = CH_M;
          new_buf[3] = CH_LF;
          new_mask[3:0] = 4'hf;
        end else begin
          new_buf[0]  = in_tdata;
          new_mask[0] = 1'b1;
        end
      end
      P_CODE: begin
        mode_nxt = P_TEXT;
        if (hv[4]) begin
          red_nxt  = hv[3:0];
          mode_nxt = P_GREEN;
        end else if (in_tdata == CH_G) begin
          new_buf[0] = CH_ESC;
          new_buf[1] = CH_LBRK;
          new_buf[2] = CH_3;
          new_buf[3] = CH_9;
          new_buf[4] = CH_SEMI;
          new_buf[5] = CH_4;
          new_buf[6] = CH_9;
          new_buf[7] = CH_M;
          new_mask[7:0] = 8'hff;
        end else if (in_tdata == CH_I) begin
          new_buf[0] = CH_ESC;
          new_buf[1] = CH_LBRK;
          new_buf[2] = CH_3;
          new_buf[3] = CH_M;
          new_mask[3:0] = 4'hf;
        end else if (in_tdata == CH_O || in_tdata == CH_S) begin
          new_buf[0] = CH_ESC;
          new_buf[1] = CH_LBRK;
          new_buf[2] = CH_1;
          new_buf[3] = CH_M;
          new_mask[3:0] = 4'hf;
        end else if (in_tdata == CH_Z) begin
          new_buf[0] = CH_ESC;
          new_buf[1] = CH_LBRK;
          new_buf[2] = CH_M;
          new_mask[2:0] = 3'h7;
        end else if (in_tdata == CH_DOLLAR) begin
          new_buf[0]  = CH_DOLLAR;
          new_mask[0] = 1'b1;
        end
      end
      P_GREEN: begin
        green_nxt = dz;
        mode_nxt  = P_BLUE;
      end
      P_BLUE: begin
        mode_nxt    = P_TEXT;
        new_buf[0]  = CH_ESC;
        new_buf[1]  = CH_LBRK;
        new_buf[2]  = CH_3;
        new_buf[3]  = CH_8;
        new_buf[4]  = CH_SEMI;
        new_buf[5]  = CH_2;
        new_buf[6]  = CH_SEMI;
        new_buf[7]  = dr[23:16];
        new_buf[8]  = dr[15:8];
        new_buf[9]  = dr[7:0];
        new_buf[10] = CH_SEMI;
        new_buf[11] = dg[23:16];
        new_buf[12] = dg[15:8];
        new_buf[13] = dg[7:0];
        new_buf[14] = CH_SEMI;
        new_buf[15] = db[23:16];
        new_buf[16] = db[15:8];
        new_buf[17] = db[7:0];
        new_buf[18] = CH_M;
        new_mask    = '1;
        // hundreds only from 7 up (105), tens from 1 up (15)
        new_mask[7]  = (red_r >= 4'd7);
        new_mask[8]  = (red_r != 4'd0);
        new_mask[11] = (green_r >= 4'd7);
        new_mask[12] = (green_r != 4'd0);
        new_mask[15] = (dz >= 4'd7);
        new_mask[16] = (dz != 4'd0);
      end
      default: begin
        mode_nxt = P_TEXT;
      end
    endcase
  end

  // job mask: load on accept, else retire the slot sent out
  always_comb begin
    job_mask_nxt = job_mask_r;
    if (in_fire) begin
      job_mask_nxt = new_mask;
    end else if (emit) begin
      job_mask_nxt = job_mask_r & ~low_bit;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= P_TEXT;
      red_r       <= '0;
      green_r     <= '0;
      rst_nl_r    <= 1'b0;
      job_mask_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        rst_nl_r <= cfg_data;
      end
      if (in_fire) begin
        mode_r  <= mode_nxt;
        red_r   <= red_nxt;
        green_r <= green_nxt;
      end
      job_mask_r <= job_mask_nxt;
      if (out_load) begin
        out_valid_r <= emit;
      end
    end
  end

  // job bytes and output payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int k = 0; k < JOB_SLOTS; k++) begin
        job_buf_r[k] <= new_buf[k];
      end
    end
    if (emit) begin
      out_data_r <= emit_byte;
      out_last_r <= job_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // a new item only enters when the current job is done or finishing
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (job_mask_r == '0) || (job_last && out_load))
    else $error("item accepted over a pending job");

  // the last slot of a job is flagged on the output
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && job_last) |=> (out_tvalid && out_tlast))
    else $error("final byte of a job not marked last");

  // a non-final slot is never flagged
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !job_last) |=> (out_tvalid && !out_tlast))
    else $error("inner byte of a job marked last");

  // reset empties the output side
  assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && job_mask_r == '0))
    else $error("output not empty after reset");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for dollar_markup_to_ansi_translator
// Drives marked-up text bytes into the translator, predicts the terminal
// bytes and run markers that each byte causes, and compares every output
// item in order. A directed table walks the codes and corner cases, then
// random code sequences run under both newline settings with random stalls.
// ----------------------------------------------------------------------------

module tb_top
  import dmat_pkg::*;
();

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 3;
  localparam int IDLE_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 24;
  localparam int RANDOM_ITEMS = 152;
  localparam int PHASES       = 4;
  localparam int PRINT_CAP    = 100;
  localparam int DIGIT_SCALE  = 15;
  localparam int DIR_ROWS     = 27;
  localparam byte_t CH_TILDE  = 8'h7e;

  typedef struct packed {
    byte_t data;
    logic  last;
  } out_item_t;

  typedef enum logic {
    ROW_TEXT,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t kind;
    byte_t     value;
    logic      typed;
    int        typed_count;
    byte_t     typed_byte;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] text_byte
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [7:0] out_byte
  logic       out_tlast;  // last_of_run
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;   // reset_on_newline

  // translator model state
  parse_mode_t model_mode;
  logic [3:0]  model_red;
  logic [3:0]  model_green;
  logic        model_nl_reset;

  byte_t     run_q[$];
  out_item_t pending_q[$];
  dir_row_t  dir_rows [DIR_ROWS];
  byte_t     code_letters [6];

  int   fail_count  = 0;
  int   idle_cycles = 0;
  int   items_sent  = 0;
  logic calm        = 1'b0;

  dollar_markup_to_ansi_translator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // hex digit value, -1 when not a digit
  function automatic int hex_digit(input byte_t c);
    if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + int'(HEX_TEN);
    if (c >= CH_LA && c <= CH_LF_HEX) return int'(c) - int'(CH_LA) + int'(HEX_TEN);
    return -1;
  endfunction

  function automatic logic [3:0] digit_or_zero(input byte_t c);
    int v;
    v = hex_digit(c);
    return (v < 0) ? 4'd0 : 4'(v);
  endfunction

  function automatic void add_text(input string s);
    for (int k = 0; k < s.len(); k++) run_q.push_back(byte_t'(s[k]));
  endfunction

  // decimal without leading zeros
  function automatic void add_decimal(input int unsigned v);
    if (v >= 100) run_q.push_back(CH_0 + byte_t'((v / 100) % 10));
    if (v >= 10) run_q.push_back(CH_0 + byte_t'((v / 10) % 10));
    run_q.push_back(CH_0 + byte_t'(v % 10));
  endfunction

  // bytes caused by one text byte, advancing the parser state
  function automatic void translate_byte(input byte_t c);
    run_q.delete();
    case (model_mode)
      P_TEXT: begin
        if (c == CH_DOLLAR) begin
          model_mode = P_CODE;
        end else begin
          if (c == CH_LF && model_nl_reset) begin
            run_q.push_back(CH_ESC);
            add_text("[m");
          end
          run_q.push_back(c);
        end
      end
      P_CODE: begin
        model_mode = P_TEXT;
        if (hex_digit(c) >= 0) begin
          model_red  = digit_or_zero(c);
          model_mode = P_GREEN;
        end else if (c == CH_G) begin
          run_q.push_back(CH_ESC);
          add_text("[39;49m");
        end else if (c == CH_I) begin
          run_q.push_back(CH_ESC);
          add_text("[3m");
        end else if (c == CH_O || c == CH_S) begin
          run_q.push_back(CH_ESC);
          add_text("[1m");
        end else if (c == CH_Z) begin
          run_q.push_back(CH_ESC);
          add_text("[m");
        end else if (c == CH_DOLLAR) begin
          run_q.push_back(CH_DOLLAR);
        end
      end
      P_GREEN: begin
        model_green = digit_or_zero(c);
        model_mode  = P_BLUE;
      end
      default: begin
        model_mode = P_TEXT;
        run_q.push_back(CH_ESC);
        add_text("[38;2;");
        add_decimal(int'(model_red) * DIGIT_SCALE);
        run_q.push_back(CH_SEMI);
        add_decimal(int'(model_green) * DIGIT_SCALE);
        run_q.push_back(CH_SEMI);
        add_decimal(int'(digit_or_zero(c)) * DIGIT_SCALE);
        run_q.push_back(CH_M);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // send one text byte and queue what it should cause
  task automatic push_text(input byte_t b, input logic typed, input int typed_count,
                           input byte_t typed_byte);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    translate_byte(b);
    if (typed) begin
      if (typed_count == 1) pending_q.push_back('{data: typed_byte, last: 1'b1});
    end else begin
      foreach (run_q[k]) pending_q.push_back('{data: run_q[k], last: (k == run_q.size() - 1)});
    end
    items_sent++;
  endtask

  // newline setting, written only once the translator has drained
  task automatic write_nl_reset(input logic v);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_nl_reset = v;
  endtask

  function automatic byte_t random_hex_char();
    int unsigned v;
    v = $urandom_range(0, 15);
    if (v < HEX_TEN) return CH_0 + byte_t'(v);
    return (($urandom_range(0, 1) == 0) ? CH_UA : CH_LA) + byte_t'(v - HEX_TEN);
  endfunction

  // later colour digits are sometimes broken
  function automatic byte_t random_colour_char();
    if ($urandom_range(0, 6) == 0) return byte_t'($urandom_range(0, 255));
    return random_hex_char();
  endfunction

  // one random sequence: plain text, newline, letter code, colour or noise
  task automatic send_random_run();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      push_text(byte_t'($urandom_range(0, 255)), 1'b0, 0, 8'h00);
    end else if (pick < 45) begin
      push_text(CH_LF, 1'b0, 0, 8'h00);
    end else if (pick < 60) begin
      push_text(CH_DOLLAR, 1'b0, 0, 8'h00);
      push_text(code_letters[$urandom_range(0, 5)], 1'b0, 0, 8'h00);
    end else if (pick < 85) begin
      push_text(CH_DOLLAR, 1'b0, 0, 8'h00);
      push_text(random_hex_char(), 1'b0, 0, 8'h00);
      push_text(random_colour_char(), 1'b0, 0, 8'h00);
      push_text(random_colour_char(), 1'b0, 0, 8'h00);
    end else begin
      push_text(CH_DOLLAR, 1'b0, 0, 8'h00);
      push_text(byte_t'($urandom_range(0, 255)), 1'b0, 0, 8'h00);
    end
  endtask

  // output stalls in random bursts
  initial begin
    out_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // compare each output item with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_tdata));
      end else begin
        want = pending_q.pop_front();
        if (out_tdata !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", out_tdata, want.data));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("tlast %b, want %b on byte %02h", out_tlast, want.last,
                                    want.data));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int phase_end;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_data  <= 1'b0;

    code_letters = '{CH_G, CH_I, CH_O, CH_S, CH_Z, CH_DOLLAR};
    dir_rows = '{
      // extremes and newline with the setting at reset
      '{ROW_TEXT, 8'h00,     1'b1, 1, 8'h00},
      '{ROW_TEXT, 8'hff,     1'b1, 1, 8'hff},
      '{ROW_TEXT, CH_LF,     1'b1, 1, CH_LF},
      // doubled dollar
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 1, CH_DOLLAR},
      // letter codes
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_G,      1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_I,      1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_O,      1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_S,      1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_Z,      1'b0, 0, 8'h00},
      // unknown code swallows a newline
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_LF,     1'b1, 0, 8'h00},
      // colour with both letter cases and a non-hex green digit
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_LF_HEX, 1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_Z,      1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_UF,     1'b0, 0, 8'h00},
      // reset before newline
      '{ROW_CFG,  8'h01,     1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_LF,     1'b0, 0, 8'h00},
      // colour with a non-hex blue digit
      '{ROW_TEXT, CH_DOLLAR, 1'b1, 0, 8'h00},
      '{ROW_TEXT, CH_0,      1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_UA,     1'b0, 0, 8'h00},
      '{ROW_TEXT, CH_TILDE,  1'b0, 0, 8'h00}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    model_mode     = P_TEXT;
    model_red      = 4'd0;
    model_green    = 4'd0;
    model_nl_reset = 1'b0;

    // directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG)
        write_nl_reset(dir_rows[r].value[0]);
      else
        push_text(dir_rows[r].value, dir_rows[r].typed, dir_rows[r].typed_count,
                  dir_rows[r].typed_byte);
    end

    // random phases, the last one without stalls
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0)
        write_nl_reset(1'b0);
      else if (ph == 1)
        write_nl_reset(1'b1);
      else
        write_nl_reset(1'($urandom_range(0, 1)));
      calm = (ph == PHASES - 1);
      phase_end = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_end) send_random_run();
    end
    in_tvalid <= 1'b0;

    // drain
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_q.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", pending_q.size()));

    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
src/dmat_pkg.sv
src/dollar_markup_to_ansi_translator.sv
tb/tb_top.sv
